### hdl/ppcr_pkg.sv
`timescale 1ns / 1ps

package ppcr_pkg;

    // Register map: one register, selected by word address bit 2.
    localparam logic REG_RESTITUTION = 1'b0;
    localparam logic [15:0] RESTITUTION_RST = 16'd52429;

    // Pipeline segment lengths.
    localparam int SQ_STAGES = 32;   // one root bit per stage
    localparam int NDIV_QW   = 17;   // unit vector quotient bits
    localparam int JDIV_QW   = 42;   // impulse quotient bits
    localparam int PDIV_QW   = 51;   // per-mass quotient bits
    localparam int DEPTH     = 4 + SQ_STAGES + 1 + NDIV_QW + 4 + JDIV_QW + 1 + PDIV_QW;

    localparam logic [16:0] UNIT_ONE = 17'd65536;

    typedef struct packed {
        logic signed [31:0] p1x;
        logic signed [31:0] p1y;
        logic signed [31:0] p2x;
        logic signed [31:0] p2y;
        logic signed [31:0] q1x;
        logic signed [31:0] q1y;
        logic signed [31:0] q2x;
        logic signed [31:0] q2y;
        logic [15:0]        m1;
        logic [15:0]        m2;
        logic [16:0]        msum;
        logic [16:0]        rsum;
        logic signed [32:0] dvx;
        logic signed [32:0] dvy;
        logic               dx_neg;
        logic               dy_neg;
        logic [32:0]        ax;
        logic [32:0]        ay;
        logic               sh;
        logic [32:0]        dlen;
        logic               degen;
        logic [16:0]        nmx;
        logic [16:0]        nmy;
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic               dot_neg;
        logic [33:0]        vel;
        logic signed [34:0] cx;
        logic signed [34:0] cy;
    } ctx_t;

    typedef struct packed {
        logic signed [31:0] p1x;
        logic signed [31:0] p1y;
        logic signed [31:0] p2x;
        logic signed [31:0] p2y;
        logic signed [31:0] q1x;
        logic signed [31:0] q1y;
        logic signed [31:0] q2x;
        logic signed [31:0] q2y;
        logic               degen;
    } res_t;

endpackage

### hdl/ppcr_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees that the quotient fits in QW bits.
module ppcr_div #(
    parameter int NW = 49,
    parameter int DW = 33,
    parameter int QW = 17
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [DW-1:0] den_reg [QW];

    genvar g;
    for (g = 0; g < QW; g++) begin : gen_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] q_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   rem_sh;
        logic          take;

        if (g == 0) begin : gen_first
            assign rem_in = DW'(num >> QW);
            assign low_in = num[QW-1:0];
            assign q_in   = '0;
            assign den_in = den;
        end else begin : gen_rest
            assign rem_in = rem_reg[g-1];
            assign low_in = low_reg[g-1];
            assign q_in   = q_reg[g-1];
            assign den_in = den_reg[g-1];
        end

        assign rem_sh = {rem_in, low_in[QW-1]};
        assign take   = (rem_sh >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= take ? DW'(rem_sh - {1'b0, den_in}) : rem_sh[DW-1:0];
                q_reg[g]   <= {q_in[QW-2:0], take};
                low_reg[g] <= {low_in[QW-2:0], 1'b0};
                den_reg[g] <= den_in;
            end
        end
    end

    assign quo = q_reg[QW-1];

endmodule

### hdl/particle_pair_collision_response.sv
// Throughput: one pair per cycle while the output buffer has a free entry;
// the pipeline of 152 stages (a bit-serial square root and three ranks of
// bit-per-stage dividers) advances as a whole.
// A two-entry output buffer lets work continue while a result waits.
// Reset (rst_n, asynchronous, active low) empties the pipeline and buffer and
// sets restitution to 52429; no clearing pass is needed.
`timescale 1ns / 1ps

module particle_pair_collision_response
    import ppcr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] first_pos_x,
    input  logic signed [31:0] first_pos_y,
    input  logic signed [31:0] second_pos_x,
    input  logic signed [31:0] second_pos_y,
    input  logic signed [31:0] first_prev_x,
    input  logic signed [31:0] first_prev_y,
    input  logic signed [31:0] second_prev_x,
    input  logic signed [31:0] second_prev_y,
    input  logic [15:0]        first_radius,
    input  logic [15:0]        second_radius,
    input  logic [15:0]        first_mass,
    input  logic [15:0]        second_mass,

    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_first_pos_x,
    output logic signed [31:0] out_first_pos_y,
    output logic signed [31:0] out_second_pos_x,
    output logic signed [31:0] out_second_pos_y,
    output logic signed [31:0] out_first_prev_x,
    output logic signed [31:0] out_first_prev_y,
    output logic signed [31:0] out_second_prev_x,
    output logic signed [31:0] out_second_prev_y,
    output logic               degenerate
);

    // Saturate a wide signed result to the signed 32-bit position range.
    function automatic logic signed [31:0] sat32(input logic signed [52:0] x);
        logic signed [52:0] hi;
        logic signed [52:0] lo;
        hi = 53'sd2147483647;
        lo = -53'sd2147483648;
        if (x > hi)
            return 32'sh7FFFFFFF;
        else if (x < lo)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration register. Write it only while the block is idle; the block itself does not enforce this.
    // ------------------------------------------------------------------
    logic [15:0] rest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rest_reg <= RESTITUTION_RST;
        else if (psel && penable && pwrite && paddr[2] == REG_RESTITUTION)
            rest_reg <= pwdata[15:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RESTITUTION) ? {16'h0000, rest_reg} : 32'h0;

    // ------------------------------------------------------------------
    // Flow control. The whole pipeline moves together whenever the output
    // buffer has a free entry; a valid bit travels with every stage.
    // ------------------------------------------------------------------
    logic             en;
    logic [1:0]       sk_cnt_reg;
    logic [DEPTH-1:0] vld_reg;

    assign en       = (sk_cnt_reg != 2'd2);
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the pair, form sums and the previous-position offset.
    // ------------------------------------------------------------------
    ctx_t c1_next, c1_reg;

    always_comb
    begin
        c1_next      = '0;
        c1_next.p1x  = first_pos_x;
        c1_next.p1y  = first_pos_y;
        c1_next.p2x  = second_pos_x;
        c1_next.p2y  = second_pos_y;
        c1_next.q1x  = first_prev_x;
        c1_next.q1y  = first_prev_y;
        c1_next.q2x  = second_prev_x;
        c1_next.q2y  = second_prev_y;
        c1_next.m1   = first_mass;
        c1_next.m2   = second_mass;
        c1_next.msum = {1'b0, first_mass} + {1'b0, second_mass};
        c1_next.rsum = {1'b0, first_radius} + {1'b0, second_radius};
        c1_next.dvx  = $signed({first_prev_x[31], first_prev_x})
                     - $signed({second_prev_x[31], second_prev_x});
        c1_next.dvy  = $signed({first_prev_y[31], first_prev_y})
                     - $signed({second_prev_y[31], second_prev_y});
    end

    always_ff @(posedge clk)
    begin
        if (en)
            c1_reg <= c1_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: offset between positions, its magnitude and the pre-shift
    // that keeps both squares within 62 bits.
    // ------------------------------------------------------------------
    ctx_t c2_next, c2_reg;
    logic signed [32:0] dx, dy;

    always_comb
    begin
        c2_next        = c1_reg;
        dx             = $signed({c1_reg.p2x[31], c1_reg.p2x})
                       - $signed({c1_reg.p1x[31], c1_reg.p1x});
        dy             = $signed({c1_reg.p2y[31], c1_reg.p2y})
                       - $signed({c1_reg.p1y[31], c1_reg.p1y});
        c2_next.dx_neg = dx[32];
        c2_next.dy_neg = dy[32];
        c2_next.ax     = dx[32] ? 33'(-dx) : 33'(dx);
        c2_next.ay     = dy[32] ? 33'(-dy) : 33'(dy);
        c2_next.sh     = c2_next.ax[32] | c2_next.ax[31] | c2_next.ay[32] | c2_next.ay[31];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            c2_reg <= c2_next;
    end

    // ------------------------------------------------------------------
    // Stage 3: squares. Stage 4: their sum, the radicand.
    // ------------------------------------------------------------------
    ctx_t        c3_reg, c4_reg;
    logic [31:0] sa, sb;
    logic [63:0] aa_reg, bb_reg, rad_reg;

    assign sa = c2_reg.sh ? c2_reg.ax[32:1] : c2_reg.ax[31:0];
    assign sb = c2_reg.sh ? c2_reg.ay[32:1] : c2_reg.ay[31:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aa_reg  <= sa * sa;
            bb_reg  <= sb * sb;
            c3_reg  <= c2_reg;
            rad_reg <= aa_reg + bb_reg;
            c4_reg  <= c3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root: one result bit per stage, rounded down.
    // ------------------------------------------------------------------
    logic [33:0] sq_rem_reg  [SQ_STAGES];
    logic [31:0] sq_root_reg [SQ_STAGES];
    logic [63:0] sq_rad_reg  [SQ_STAGES];
    ctx_t        sq_ctx_reg  [SQ_STAGES];

    genvar g;
    for (g = 0; g < SQ_STAGES; g++) begin : gen_sqrt
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] rad_in;
        logic [35:0] rem_sh;
        logic [35:0] trial;

        if (g == 0) begin : gen_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad_reg;
        end else begin : gen_rest
            assign rem_in  = sq_rem_reg[g-1];
            assign root_in = sq_root_reg[g-1];
            assign rad_in  = sq_rad_reg[g-1];
        end

        assign rem_sh = {rem_in, rad_in[63:62]};
        assign trial  = {2'b00, root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_sh >= trial)
                begin
                    sq_rem_reg[g]  <= 34'(rem_sh - trial);
                    sq_root_reg[g] <= {root_in[30:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg[g]  <= rem_sh[33:0];
                    sq_root_reg[g] <= {root_in[30:0], 1'b0};
                end
                sq_rad_reg[g] <= {rad_in[61:0], 2'b00};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_ctx_reg[0] <= c4_reg;
            for (int k = 1; k < SQ_STAGES; k++)
                sq_ctx_reg[k] <= sq_ctx_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage after the root: undo the pre-shift and flag the cases that pass
    // the pair through with the degenerate flag set.
    // ------------------------------------------------------------------
    ctx_t c5_next, c5_reg;

    always_comb
    begin
        c5_next       = sq_ctx_reg[SQ_STAGES-1];
        c5_next.dlen  = c5_next.sh ? {sq_root_reg[SQ_STAGES-1], 1'b0}
                                   : {1'b0, sq_root_reg[SQ_STAGES-1]};
        c5_next.degen = (c5_next.dlen == 33'h0) || (c5_next.msum == 17'h0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            c5_reg <= c5_next;
    end

    // ------------------------------------------------------------------
    // Unit direction: |d| * 65536 / dist per component.
    // ------------------------------------------------------------------
    logic [NDIV_QW-1:0] nqx, nqy;
    ctx_t               nd_ctx_reg [NDIV_QW];

    ppcr_div #(.NW(49), .DW(33), .QW(NDIV_QW)) u_div_nx (
        .clk (clk),
        .en  (en),
        .num ({c5_reg.ax, 16'h0000}),
        .den (c5_reg.dlen),
        .quo (nqx)
    );

    ppcr_div #(.NW(49), .DW(33), .QW(NDIV_QW)) u_div_ny (
        .clk (clk),
        .en  (en),
        .num ({c5_reg.ay, 16'h0000}),
        .den (c5_reg.dlen),
        .quo (nqy)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nd_ctx_reg[0] <= c5_reg;
            for (int k = 1; k < NDIV_QW; k++)
                nd_ctx_reg[k] <= nd_ctx_reg[k-1];
        end
    end

    // Clamp to one and restore the sign of the offset.
    ctx_t c6_next, c6_reg;

    always_comb
    begin
        c6_next     = nd_ctx_reg[NDIV_QW-1];
        c6_next.nmx = (nqx > UNIT_ONE) ? UNIT_ONE : nqx;
        c6_next.nmy = (nqy > UNIT_ONE) ? UNIT_ONE : nqy;
        c6_next.nx  = c6_next.dx_neg ? -$signed({1'b0, c6_next.nmx})
                                     :  $signed({1'b0, c6_next.nmx});
        c6_next.ny  = c6_next.dy_neg ? -$signed({1'b0, c6_next.nmy})
                                     :  $signed({1'b0, c6_next.nmy});
    end

    always_ff @(posedge clk)
    begin
        if (en)
            c6_reg <= c6_next;
    end

    // ------------------------------------------------------------------
    // Projection terms and the overlap correction products.
    // ------------------------------------------------------------------
    ctx_t               c7_reg;
    logic signed [33:0] overlap;
    logic signed [50:0] pdx_reg, pdy_reg;
    logic signed [51:0] pox_reg, poy_reg;

    assign overlap = $signed({9'h000, c6_reg.rsum, 8'h00}) - $signed({1'b0, c6_reg.dlen});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pdx_reg <= 51'(c6_reg.dvx * c6_reg.nx);
            pdy_reg <= 51'(c6_reg.dvy * c6_reg.ny);
            pox_reg <= 52'(overlap * c6_reg.nx);
            poy_reg <= 52'(overlap * c6_reg.ny);
            c7_reg  <= c6_reg;
        end
    end

    // Signed dot product, and the half-overlap push divided toward zero.
    ctx_t               c8_next, c8_reg;
    logic signed [51:0] dot;
    logic [51:0]        pmx, pmy;

    always_comb
    begin
        c8_next         = c7_reg;
        dot             = 52'(pdx_reg) + 52'(pdy_reg);
        c8_next.dot_neg = dot[51];
        c8_next.vel     = dot[49:16];
        pmx             = pox_reg[51] ? 52'(-pox_reg) : 52'(pox_reg);
        pmy             = poy_reg[51] ? 52'(-poy_reg) : 52'(poy_reg);
        c8_next.cx      = pox_reg[51] ? -$signed({1'b0, pmx[50:17]}) : $signed({1'b0, pmx[50:17]});
        c8_next.cy      = poy_reg[51] ? -$signed({1'b0, pmy[50:17]}) : $signed({1'b0, pmy[50:17]});
    end

    always_ff @(posedge clk)
    begin
        if (en)
            c8_reg <= c8_next;
    end

    // Restitution times the projected speed.
    ctx_t        c9_reg;
    logic [49:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= rest_reg * c8_reg.vel;
            c9_reg   <= c8_reg;
        end
    end

    // ------------------------------------------------------------------
    // Impulse: (restitution * v / 256) / (m1 + m2).
    // ------------------------------------------------------------------
    logic [JDIV_QW-1:0] jimp;
    ctx_t               jd_ctx_reg [JDIV_QW];

    ppcr_div #(.NW(JDIV_QW), .DW(17), .QW(JDIV_QW)) u_div_j (
        .clk (clk),
        .en  (en),
        .num (prod_reg[49:8]),
        .den (c9_reg.msum),
        .quo (jimp)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            jd_ctx_reg[0] <= c9_reg;
            for (int k = 1; k < JDIV_QW; k++)
                jd_ctx_reg[k] <= jd_ctx_reg[k-1];
        end
    end

    // Impulse along each axis.
    ctx_t        c10_reg;
    logic [58:0] jx_reg, jy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            jx_reg  <= jimp * jd_ctx_reg[JDIV_QW-1].nmx;
            jy_reg  <= jimp * jd_ctx_reg[JDIV_QW-1].nmy;
            c10_reg <= jd_ctx_reg[JDIV_QW-1];
        end
    end

    // ------------------------------------------------------------------
    // Per-particle change of the previous position: (J * |n| / 256) / m.
    // ------------------------------------------------------------------
    logic [PDIV_QW-1:0] q1dx, q1dy, q2dx, q2dy;
    ctx_t               pd_ctx_reg [PDIV_QW];

    ppcr_div #(.NW(PDIV_QW), .DW(16), .QW(PDIV_QW)) u_div_1x (
        .clk (clk), .en (en), .num (jx_reg[58:8]), .den (c10_reg.m1), .quo (q1dx)
    );

    ppcr_div #(.NW(PDIV_QW), .DW(16), .QW(PDIV_QW)) u_div_1y (
        .clk (clk), .en (en), .num (jy_reg[58:8]), .den (c10_reg.m1), .quo (q1dy)
    );

    ppcr_div #(.NW(PDIV_QW), .DW(16), .QW(PDIV_QW)) u_div_2x (
        .clk (clk), .en (en), .num (jx_reg[58:8]), .den (c10_reg.m2), .quo (q2dx)
    );

    ppcr_div #(.NW(PDIV_QW), .DW(16), .QW(PDIV_QW)) u_div_2y (
        .clk (clk), .en (en), .num (jy_reg[58:8]), .den (c10_reg.m2), .quo (q2dy)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pd_ctx_reg[0] <= c10_reg;
            for (int k = 1; k < PDIV_QW; k++)
                pd_ctx_reg[k] <= pd_ctx_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Final assembly with saturation. A degenerate pair, or one whose
    // particles are already moving apart, passes through unchanged. A
    // particle of zero mass gets no impulse change.
    // ------------------------------------------------------------------
    ctx_t               cf;
    res_t               res_next;
    logic signed [52:0] d1x, d1y, d2x, d2y;

    assign cf = pd_ctx_reg[PDIV_QW-1];

    always_comb
    begin
        d1x = (cf.m1 == 16'h0) ? 53'sd0
            : (cf.nx[17] ? -$signed({2'b00, q1dx}) : $signed({2'b00, q1dx}));
        d1y = (cf.m1 == 16'h0) ? 53'sd0
            : (cf.ny[17] ? -$signed({2'b00, q1dy}) : $signed({2'b00, q1dy}));
        d2x = (cf.m2 == 16'h0) ? 53'sd0
            : (cf.nx[17] ? -$signed({2'b00, q2dx}) : $signed({2'b00, q2dx}));
        d2y = (cf.m2 == 16'h0) ? 53'sd0
            : (cf.ny[17] ? -$signed({2'b00, q2dy}) : $signed({2'b00, q2dy}));

        res_next.degen = cf.degen;
        if (cf.degen || cf.dot_neg)
        begin
            res_next.p1x = cf.p1x;
            res_next.p1y = cf.p1y;
            res_next.p2x = cf.p2x;
            res_next.p2y = cf.p2y;
            res_next.q1x = cf.q1x;
            res_next.q1y = cf.q1y;
            res_next.q2x = cf.q2x;
            res_next.q2y = cf.q2y;
        end
        else
        begin
            res_next.p1x = sat32(53'(cf.p1x) - 53'(cf.cx));
            res_next.p1y = sat32(53'(cf.p1y) - 53'(cf.cy));
            res_next.p2x = sat32(53'(cf.p2x) + 53'(cf.cx));
            res_next.p2y = sat32(53'(cf.p2y) + 53'(cf.cy));
            res_next.q1x = sat32(53'(cf.q1x) + d1x);
            res_next.q1y = sat32(53'(cf.q1y) + d1y);
            res_next.q2x = sat32(53'(cf.q2x) - d2x);
            res_next.q2y = sat32(53'(cf.q2y) - d2y);
        end
    end

    // ------------------------------------------------------------------
    // Two-entry output buffer. The pipeline stops only when both are full.
    // ------------------------------------------------------------------
    res_t sk_mem_reg [2];
    logic sk_wr_reg, sk_rd_reg;
    logic push, pop;

    assign push      = en && vld_reg[DEPTH-1];
    assign out_valid = (sk_cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sk_cnt_reg <= 2'd0;
            sk_wr_reg  <= 1'b0;
            sk_rd_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                sk_wr_reg <= ~sk_wr_reg;
            if (pop)
                sk_rd_reg <= ~sk_rd_reg;
            sk_cnt_reg <= sk_cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            sk_mem_reg[sk_wr_reg] <= res_next;
    end

    assign out_first_pos_x   = sk_mem_reg[sk_rd_reg].p1x;
    assign out_first_pos_y   = sk_mem_reg[sk_rd_reg].p1y;
    assign out_second_pos_x  = sk_mem_reg[sk_rd_reg].p2x;
    assign out_second_pos_y  = sk_mem_reg[sk_rd_reg].p2y;
    assign out_first_prev_x  = sk_mem_reg[sk_rd_reg].q1x;
    assign out_first_prev_y  = sk_mem_reg[sk_rd_reg].q1y;
    assign out_second_prev_x = sk_mem_reg[sk_rd_reg].q2x;
    assign out_second_prev_y = sk_mem_reg[sk_rd_reg].q2y;
    assign degenerate        = sk_mem_reg[sk_rd_reg].degen;

endmodule

### hdl/ppcr_checker.sv
`timescale 1ns / 1ps

module ppcr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] out_first_pos_x,
    input logic               degenerate
);

    // The input side is held back only while results are waiting.
    a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result waiting");

    // Reset empties the output buffer, so nothing is offered straight after it.
    a_empty_after_reset: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result offered straight after reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_first_pos_x) && $stable(degenerate))
        else $error("result changed before transfer");

endmodule

bind particle_pair_collision_response ppcr_checker u_ppcr_checker (.*);

### verif/testbench.sv
`timescale 1ns / 1ps

// Testbench for the particle pair collision response block. Pairs are sent
// in bursts with random gaps while the result side stalls on its own
// pattern, and every result transfer is compared field by field against a
// typed-in value or a fixed-point collision predictor. The restitution
// register is stepped through several settings, block idle at each change.
module testbench;
    import ppcr_pkg::*;

    typedef struct packed {
        logic signed [31:0] p1x;
        logic signed [31:0] p1y;
        logic signed [31:0] p2x;
        logic signed [31:0] p2y;
        logic signed [31:0] q1x;
        logic signed [31:0] q1y;
        logic signed [31:0] q2x;
        logic signed [31:0] q2y;
        logic [15:0]        r1;
        logic [15:0]        r2;
        logic [15:0]        m1;
        logic [15:0]        m2;
    } pair_t;

    typedef struct {
        pair_t stim;
        bit    known;
        res_t  want;
    } row_t;

    localparam logic [2:0] RESTITUTION_ADDR = {REG_RESTITUTION, 2'b00};
    localparam int DRAIN_CYCLES = 160;
    localparam int ITEMS_PER_PHASE = 250;

    logic clk;
    logic rst_n;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    pair_t drive_pair = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    res_t got;

    // Predictor copy of the restitution register and the results still owed.
    logic [15:0] restitution_now = RESTITUTION_RST;
    res_t        owed_results[$];
    int          errors = 0;

    // Long hold-off request from the stimulus side to the result side.
    bit hold_request = 1'b0;
    int burst_left = 0;

    particle_pair_collision_response uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .first_pos_x(drive_pair.p1x), .first_pos_y(drive_pair.p1y),
        .second_pos_x(drive_pair.p2x), .second_pos_y(drive_pair.p2y),
        .first_prev_x(drive_pair.q1x), .first_prev_y(drive_pair.q1y),
        .second_prev_x(drive_pair.q2x), .second_prev_y(drive_pair.q2y),
        .first_radius(drive_pair.r1), .second_radius(drive_pair.r2),
        .first_mass(drive_pair.m1), .second_mass(drive_pair.m2),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_first_pos_x(got.p1x), .out_first_pos_y(got.p1y),
        .out_second_pos_x(got.p2x), .out_second_pos_y(got.p2y),
        .out_first_prev_x(got.q1x), .out_first_prev_y(got.q1y),
        .out_second_prev_x(got.q2x), .out_second_prev_y(got.q2y),
        .degenerate(got.degen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Generous limit: far beyond the slowest legal run with all stalls.
    initial
    begin
        #(20 * 800000);
        $display("Test completed with failures");
        $finish;
    end

    // Floor of the square root, one result bit per pass.
    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] probe;
        res = 0;
        probe = 64'd1 << 62;
        while (probe > v)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (v >= res + probe)
            begin
                v = v - (res + probe);
                res = (res >> 1) + probe;
            end
            else
                res = res >> 1;
            probe = probe >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] clip32(longint x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic longint unit_part(longint d, longint dlen);
        longint n;
        n = (d * 65536) / dlen;
        if (n > 65536)
            n = 65536;
        if (n < -65536)
            n = -65536;
        return n;
    endfunction

    // Share of the impulse taken by one particle; a massless one takes none.
    function automatic longint mass_share(longint j, longint n, logic [15:0] m);
        logic [63:0] q;
        if (m == 0)
            return 0;
        q = (64'(j) * 64'(n < 0 ? -n : n)) / (64'(m) * 256);
        return n < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic res_t collide(pair_t p, logic [15:0] rest);
        longint dx, dy, ax, ay, dlen, nx, ny, dot, vel, jimp, overlap, cx, cy;
        longint o[8];
        logic [63:0] a, b, msum;
        int sh;
        res_t r;
        o[0] = p.p1x; o[1] = p.p1y; o[2] = p.p2x; o[3] = p.p2y;
        o[4] = p.q1x; o[5] = p.q1y; o[6] = p.q2x; o[7] = p.q2y;
        msum = 64'(p.m1) + 64'(p.m2);
        dx = longint'(p.p2x) - longint'(p.p1x);
        dy = longint'(p.p2y) - longint'(p.p1y);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        // Halve both offsets when either is too large to square safely.
        sh = (ax >= 64'sd2147483648 || ay >= 64'sd2147483648) ? 1 : 0;
        a = 64'(ax) >> sh;
        b = 64'(ay) >> sh;
        dlen = longint'(root_floor(a * a + b * b) << sh);
        r.degen = 1'b0;
        if (dlen == 0 || msum == 0)
            r.degen = 1'b1;
        else
        begin
            nx = unit_part(dx, dlen);
            ny = unit_part(dy, dlen);
            dot = (longint'(p.q1x) - longint'(p.q2x)) * nx
                + (longint'(p.q1y) - longint'(p.q2y)) * ny;
            // Pairs already moving apart are left untouched.
            if (dot >= 0)
            begin
                vel = dot / 65536;
                jimp = longint'((64'(rest) * 64'(vel)) / (msum * 256));
                overlap = longint'((64'(p.r1) + 64'(p.r2)) * 256) - dlen;
                cx = (overlap * nx) / 131072;
                cy = (overlap * ny) / 131072;
                o[0] = o[0] - cx; o[1] = o[1] - cy;
                o[2] = o[2] + cx; o[3] = o[3] + cy;
                o[4] = o[4] + mass_share(jimp, nx, p.m1);
                o[5] = o[5] + mass_share(jimp, ny, p.m1);
                o[6] = o[6] - mass_share(jimp, nx, p.m2);
                o[7] = o[7] - mass_share(jimp, ny, p.m2);
            end
        end
        r.p1x = clip32(o[0]); r.p1y = clip32(o[1]);
        r.p2x = clip32(o[2]); r.p2y = clip32(o[3]);
        r.q1x = clip32(o[4]); r.q1y = clip32(o[5]);
        r.q2x = clip32(o[6]); r.q2y = clip32(o[7]);
        return r;
    endfunction

    function automatic res_t unchanged(pair_t p, logic degen);
        res_t r;
        r = '{p.p1x, p.p1y, p.p2x, p.p2y, p.q1x, p.q1y, p.q2x, p.q2y, degen};
        return r;
    endfunction

    // Offers one pair and returns once its transfer has happened. Valid is
    // left high so that a following call within the burst keeps it asserted.
    task automatic offer_pair(pair_t p, bit known, res_t want);
        in_valid <= 1'b1;
        drive_pair <= p;
        do
            @(posedge clk);
        while (!in_ready);
        owed_results.push_back(known ? want : collide(p, restitution_now));
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    // Stops sending and waits until every owed result has been collected.
    task automatic drain;
        in_valid <= 1'b0;
        while (owed_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_restitution(logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= RESTITUTION_ADDR;
        pwdata <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        restitution_now = value;
    endtask

    function automatic logic signed [31:0] wobble(int span_bits);
        logic [31:0] w;
        w = $urandom >> (32 - span_bits);
        return $urandom_range(0, 1) ? -$signed(w) : $signed(w);
    endfunction

    // Mostly a pair that is approaching and overlapping, with random content;
    // otherwise every field is uniformly random.
    function automatic pair_t random_pair();
        pair_t p;
        logic signed [31:0] dx, dy;
        if ($urandom_range(0, 9) < 3)
        begin
            p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom)};
            return p;
        end
        dx = wobble($urandom_range(1, 24));
        dy = wobble($urandom_range(1, 24));
        p.p1x = $urandom;
        p.p1y = $urandom;
        p.p2x = p.p1x + dx;
        p.p2y = p.p1y + dy;
        p.q2x = p.p2x + wobble($urandom_range(1, 20));
        p.q2y = p.p2y + wobble($urandom_range(1, 20));
        p.q1x = p.q2x + (dx >>> $urandom_range(0, 4)) + wobble(8);
        p.q1y = p.q2y + (dy >>> $urandom_range(0, 4)) + wobble(8);
        p.r1 = $urandom;
        p.r2 = $urandom;
        p.m1 = $urandom_range(0, 15) == 0 ? 16'd0 : 16'($urandom);
        p.m2 = $urandom_range(0, 15) == 0 ? 16'd0 : 16'($urandom);
        return p;
    endfunction

    // Result side: switches among four stall patterns, and on request
    // holds off for a long stretch so that the pipeline fills and backs up.
    initial
    begin
        int hold_left;
        int cycle;
        int mode;
        hold_left = 0;
        cycle = 0;
        mode = 0;
        forever
        begin
            @(posedge clk);
            cycle++;
            if (cycle % 64 == 0)
                mode = $urandom_range(0, 3);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (mode == 0)
                out_ready <= 1'b1;
            else if (mode == 1)
                out_ready <= $urandom_range(0, 1);
            else if (mode == 2)
                out_ready <= $urandom_range(0, 4) != 0;
            else
                out_ready <= $urandom_range(0, 4) == 0;
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
        if (want !== seen)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
            errors++;
        end
    endtask

    // Every result transfer is matched against the oldest owed result.
    initial
    begin
        res_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t: unexpected result transfer, expected none, actual %h",
                             $time, got);
                    errors++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("out_first_pos_x", want.p1x, got.p1x);
                    check_field("out_first_pos_y", want.p1y, got.p1y);
                    check_field("out_second_pos_x", want.p2x, got.p2x);
                    check_field("out_second_pos_y", want.p2y, got.p2y);
                    check_field("out_first_prev_x", want.q1x, got.q1x);
                    check_field("out_first_prev_y", want.q1y, got.q1y);
                    check_field("out_second_prev_x", want.q2x, got.q2x);
                    check_field("out_second_prev_y", want.q2y, got.q2y);
                    check_field("degenerate", 32'(want.degen), 32'(got.degen));
                end
            end
        end
    end

    initial
    begin
        row_t rows[$];
        pair_t p;
        logic [15:0] settings[5];
        res_t none;
        none = '0;
        settings = '{RESTITUTION_RST, 16'd0, 16'hffff, 16'h8000, 16'($urandom)};

        // Directed pairs. Pass-through results are typed in; the rest go to
        // the predictor.
        p = '{32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536, 32'sd100, -32'sd100,
              32'sd7, 32'sd9, 16'h0100, 16'h0100, 16'h0100, 16'h0100};
        rows.push_back('{p, 1'b1, unchanged(p, 1'b1)});       // coincident
        p = '{32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd65536, 32'sd0,
              32'sd0, 32'sd0, 16'h0100, 16'h0100, 16'h0000, 16'h0000};
        rows.push_back('{p, 1'b1, unchanged(p, 1'b1)});       // massless pair
        p = '{32'sd0, 32'sd0, 32'sd65536, 32'sd0, -32'sd65536, 32'sd0,
              32'sd0, 32'sd0, 16'h0100, 16'h0100, 16'h0100, 16'h0100};
        rows.push_back('{p, 1'b1, unchanged(p, 1'b0)});       // moving apart
        p = '{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
              32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
              16'hffff, 16'hffff, 16'h0001, 16'h0001};
        rows.push_back('{p, 1'b0, none});                     // widest offsets
        p = '{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
              32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
              16'hffff, 16'hffff, 16'hffff, 16'hffff};
        rows.push_back('{p, 1'b0, none});
        p = '{32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd131072, 32'sd0,
              32'sd0, 32'sd0, 16'h0100, 16'h0100, 16'h0000, 16'h0100};
        rows.push_back('{p, 1'b0, none});                     // first massless
        p = '{32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd131072,
              32'sd0, 32'sd0, 16'h0100, 16'h0100, 16'h0100, 16'h0000};
        rows.push_back('{p, 1'b0, none});                     // second massless
        p = '{32'sd0, 32'sd0, 32'sd6553600, 32'sd0, 32'sd65536, 32'sd0,
              32'sd0, 32'sd0, 16'h0100, 16'h0100, 16'h0100, 16'h0100};
        rows.push_back('{p, 1'b0, none});                     // no overlap
        p = '{32'sd0, 32'sd0, -32'sd65536, -32'sd65536, -32'sd70000, -32'sd70000,
              32'sd0, 32'sd0, 16'hffff, 16'h0000, 16'hffff, 16'hffff};
        rows.push_back('{p, 1'b0, none});                     // negative direction
        p = '{32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd1, 32'sd0,
              32'sd0, 32'sd0, 16'h0000, 16'h0000, 16'h0001, 16'h0000};
        rows.push_back('{p, 1'b0, none});                     // smallest offset
        p = '{32'sd5, -32'sd5, 32'sd5, -32'sd4, 32'sd5, -32'sd5,
              32'sd5, -32'sd5, 16'h0001, 16'h0001, 16'h0001, 16'h0001};
        rows.push_back('{p, 1'b0, none});                     // zero relative motion

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pairs run at the reset restitution first.
        foreach (rows[i])
            offer_pair(rows[i].stim, rows[i].known, rows[i].want);
        drain();

        foreach (settings[ph])
        begin
            if (ph > 0)
                write_restitution(settings[ph]);
            if (ph == 1 || ph == 2)
                foreach (rows[i])
                    offer_pair(rows[i].stim, rows[i].known, rows[i].want);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // In the middle phase the result side stops for a long time
                // while pairs keep coming, so the input must back up.
                if (ph == 2 && n == 20)
                    hold_request = 1'b1;
                offer_pair(random_pair(), 1'b0, none);
            end
            drain();
        end

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
hdl/ppcr_pkg.sv
hdl/ppcr_div.sv
hdl/particle_pair_collision_response.sv
hdl/ppcr_checker.sv
verif/testbench.sv
